FILE: design/postfix_expression_evaluator_unit_defines.svh
// Assertion macros shared by the evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define PFX_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Same-cycle implication.
`define PFX_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PFX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pfx_eval_pkg.sv
// Constants, widths and helpers for the postfix evaluator.
package pfx_eval_pkg;

   localparam int DATA_W = 48;
   localparam int HALF_W = DATA_W / 2;
   localparam int PROD_W = 2 * DATA_W;

   localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // magnitude of a two's complement word; the most negative value maps to 2^47
   function automatic logic [DATA_W-1:0] fx_mag(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
      return r;
   endfunction

endpackage

FILE: design/postfix_expression_evaluator_unit.sv
// Postfix (RPN) evaluator: byte-serial tokeniser, RAM operand stack, Q fixed-point ALU.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  req     | in  | req_valid/req_stall  | req_ch[7:0], req_last
//  rsp     | out | rsp_valid/rsp_stall  | rsp_value[47:0] signed, rsp_error
//
// States per request (accept to ready again):
//   space, digit, skipped char : S_IDLE, S_EXEC, S_END
//   + or -                     : adds S_RD1, S_RD2, S_CALC, S_WB (two stack RAM reads, one write)
//   *                          : adds S_MUL loop (four 24x24 partial products, pipelined), S_SAT
//   /                          : adds S_DIV loop (restoring divider, 1 quotient bit/cycle), S_SAT
// The divider loop sets the worst case. Reset is synchronous and clears the
// control state only; the stack RAM is only read below the fill count, so it
// needs no clearing pass. A request marked last waits in its final state while
// rsp holds an untaken result; other requests proceed under a stalled rsp.
module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_ch,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pfx_eval_pkg::DATA_W-1:0]  rsp_value,
   output logic                                    rsp_error
);
   import pfx_eval_pkg::*;

   localparam int AW     = $clog2(STACK_DEPTH);
   localparam int CW     = $clog2(STACK_DEPTH + 1);
   localparam int ACC_W  = DATA_W - 1 - FRAC_BITS;   // integer part of a literal
   localparam int DW     = DATA_W + FRAC_BITS;       // dividend / quotient width
   localparam int STEP_W = $clog2(DW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_RD1, S_RD2, S_CALC, S_MUL, S_DIV, S_SAT, S_WB, S_END
   } state_type;

   state_type state_ff, state_in;

   // control
   logic [CW-1:0]     count_ff, count_in;
   logic              in_num_ff, in_num_in;
   logic              closed_ff, closed_in;
   logic              in_op_ff, in_op_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] total_ff, total_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   // payload
   logic [7:0]        ch_ff, ch_in;
   logic              last_ff, last_in;
   logic signed [DATA_W-1:0] op1_ff, op1_in;
   logic signed [DATA_W-1:0] op2_ff, op2_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] ma_ff, ma_in;
   logic [DATA_W-1:0] mb_ff, mb_in;
   logic [PROD_W-1:0] wide_ff, wide_in;   // product accumulator / quotient shifter
   logic [DATA_W-1:0] pp_ff, pp_in;
   logic [1:0]        psel_ff, psel_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_error_ff, rsp_error_in;

   // stack RAM
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   pfx_eval_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   always_comb begin
      logic              digit;
      logic [3:0]        dval;
      logic [ACC_W+3:0]  acc10;
      logic signed [DATA_W:0] sum;
      logic [6:0]        shamt;
      logic [DATA_W-1:0] remsh;
      logic              qb;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] lim;
      logic [DATA_W-1:0] m48;
      logic              rsp_free;

      digit    = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
      dval     = 4'(ch_ff - CH_ZERO);
      acc10    = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + (ACC_W+4)'(dval);
      sum      = '0;
      shamt    = '0;
      remsh    = '0;
      qb       = 1'b0;
      mag      = '0;
      lim      = '0;
      m48      = '0;
      rsp_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      count_in     = count_ff;
      in_num_in    = in_num_ff;
      closed_in    = closed_ff;
      in_op_in     = in_op_ff;
      err_in       = err_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      op1_in       = op1_ff;
      op2_in       = op2_ff;
      res_in       = res_ff;
      neg_in       = neg_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      wide_in      = wide_ff;
      pp_in        = pp_ff;
      psel_in      = psel_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in    = req_ch;
               last_in  = req_last;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_END;
            if (ch_ff == CH_SPACE) begin
               // token end: push a pending literal
               if (in_num_ff) begin
                  if (count_ff < CW'(STACK_DEPTH)) begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(count_ff);
                     ram_wdata = DATA_W'(acc_ff) << FRAC_BITS;
                     count_in  = count_ff + CW'(1);
                  end else begin
                     err_in = 1'b1;
                  end
               end
               in_num_in = 1'b0;
               closed_in = 1'b0;
               in_op_in  = 1'b0;
               acc_in    = '0;
            end else if (in_num_ff) begin
               if (digit && !closed_ff) begin
                  if (acc10[ACC_W+3:ACC_W] != 4'd0) begin
                     acc_in = '1;
                     err_in = 1'b1;
                  end else begin
                     acc_in = acc10[ACC_W-1:0];
                  end
               end else begin
                  closed_in = 1'b1;
               end
            end else if (!in_op_ff) begin
               if (digit) begin
                  in_num_in = 1'b1;
                  closed_in = 1'b0;
                  acc_in    = ACC_W'(dval);
               end else begin
                  in_op_in = 1'b1;
                  if (count_ff < CW'(2)) begin
                     err_in = 1'b1;
                  end else begin
                     ram_raddr = AW'(count_ff - CW'(1));
                     state_in  = S_RD1;
                  end
               end
            end
         end

         S_RD1: begin
            op1_in    = ram_rdata;
            ram_raddr = AW'(count_ff - CW'(2));
            state_in  = S_RD2;
         end

         S_RD2: begin
            op2_in   = ram_rdata;
            count_in = count_ff - CW'(2);
            state_in = S_CALC;
         end

         S_CALC: begin
            case (ch_ff)
               CH_PLUS, CH_MINUS: begin
                  if (ch_ff == CH_PLUS) begin
                     sum = {op2_ff[DATA_W-1], op2_ff} + {op1_ff[DATA_W-1], op1_ff};
                  end else begin
                     sum = {op2_ff[DATA_W-1], op2_ff} - {op1_ff[DATA_W-1], op1_ff};
                  end
                  if (sum[DATA_W] != sum[DATA_W-1]) begin
                     res_in = sum[DATA_W] ? NEG_MIN : POS_MAX;
                     err_in = 1'b1;
                  end else begin
                     res_in = sum[DATA_W-1:0];
                  end
                  state_in = S_WB;
               end
               CH_STAR: begin
                  neg_in   = op2_ff[DATA_W-1] ^ op1_ff[DATA_W-1];
                  ma_in    = fx_mag(op2_ff);
                  mb_in    = fx_mag(op1_ff);
                  wide_in  = '0;
                  step_in  = '0;
                  state_in = S_MUL;
               end
               CH_SLASH: begin
                  if (op1_ff == '0) begin
                     err_in = 1'b1;
                     if (op2_ff == '0) begin
                        res_in = '0;
                     end else begin
                        res_in = op2_ff[DATA_W-1] ? NEG_MIN : POS_MAX;
                     end
                     state_in = S_WB;
                  end else begin
                     neg_in   = op2_ff[DATA_W-1] ^ op1_ff[DATA_W-1];
                     mb_in    = fx_mag(op1_ff);
                     wide_in  = PROD_W'(fx_mag(op2_ff)) << FRAC_BITS;
                     rem_in   = '0;
                     step_in  = STEP_W'(DW);
                     state_in = S_DIV;
                  end
               end
               default: begin
                  // non-arithmetic token: operands dropped, nothing pushed
                  state_in = S_END;
               end
            endcase
         end

         S_MUL: begin
            // issue partial product k, accumulate product k-1
            if (step_ff < STEP_W'(4)) begin
               pp_in   = (step_ff[1] ? ma_ff[DATA_W-1:HALF_W] : ma_ff[HALF_W-1:0])
                       * (step_ff[0] ? mb_ff[DATA_W-1:HALF_W] : mb_ff[HALF_W-1:0]);
               psel_in = step_ff[1:0];
            end
            if (step_ff != '0) begin
               case (psel_ff)
                  2'b00:   shamt = 7'd0;
                  2'b11:   shamt = 7'(2 * HALF_W);
                  default: shamt = 7'(HALF_W);
               endcase
               wide_in = wide_ff + (PROD_W'(pp_ff) << shamt);
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(4)) begin
               state_in = S_SAT;
            end
         end

         S_DIV: begin
            remsh = {rem_ff[DATA_W-2:0], wide_ff[DW-1]};
            if (remsh >= mb_ff) begin
               rem_in = remsh - mb_ff;
               qb     = 1'b1;
            end else begin
               rem_in = remsh;
            end
            wide_in = PROD_W'({wide_ff[DW-2:0], qb});
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_SAT;
            end
         end

         S_SAT: begin
            mag = (ch_ff == CH_STAR) ? (wide_ff >> FRAC_BITS) : wide_ff;
            lim = neg_ff ? PROD_W'(NEG_MIN) : PROD_W'(POS_MAX);
            if (mag > lim) begin
               m48    = lim[DATA_W-1:0];
               err_in = 1'b1;
            end else begin
               m48 = mag[DATA_W-1:0];
            end
            res_in   = neg_ff ? DATA_W'(-m48) : m48;
            state_in = S_WB;
         end

         S_WB: begin
            // the two pops leave room, so this push never overflows
            ram_we    = 1'b1;
            ram_waddr = AW'(count_ff);
            ram_wdata = res_ff;
            count_in  = count_ff + CW'(1);
            total_in  = res_ff;
            state_in  = S_END;
         end

         S_END: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = total_ff;
               // a literal closed by the end of text overflows a full stack
               rsp_error_in = err_ff || (in_num_ff && (count_ff >= CW'(STACK_DEPTH)));
               count_in     = '0;
               total_in     = '0;
               err_in       = 1'b0;
               in_num_in    = 1'b0;
               closed_in    = 1'b0;
               in_op_in     = 1'b0;
               acc_in       = '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         in_num_ff    <= 1'b0;
         closed_ff    <= 1'b0;
         in_op_ff     <= 1'b0;
         err_ff       <= 1'b0;
         total_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         in_num_ff    <= in_num_in;
         closed_ff    <= closed_in;
         in_op_ff     <= in_op_in;
         err_ff       <= err_in;
         total_ff     <= total_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff        <= ch_in;
      last_ff      <= last_in;
      op1_ff       <= op1_in;
      op2_ff       <= op2_in;
      res_ff       <= res_in;
      neg_ff       <= neg_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      wide_ff      <= wide_in;
      pp_ff        <= pp_in;
      psel_ff      <= psel_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

`include "postfix_expression_evaluator_unit_defines.svh"

   `PFX_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(STACK_DEPTH), "stack count beyond depth")
   `PFX_ASSERT_ALWAYS(a_token_mode, !(in_num_ff && in_op_ff), "number and operator token at once")
   `PFX_ASSERT_IMPL(a_ram_write_src, ram_we, (state_ff == S_WB) || ((state_ff == S_EXEC) && (count_ff < CW'(STACK_DEPTH))), "stack write out of place")
   `PFX_ASSERT_NEXT(a_clear_after_result, (state_ff == S_END) && last_ff && (!rsp_valid_ff || !rsp_stall), (count_ff == '0) && !err_ff && (total_ff == '0) && rsp_valid_ff, "expression state not cleared after result")

endmodule

FILE: design/pfx_eval_ram.sv
// Generic single write port RAM with one registered read port.
module pfx_eval_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/rpn_result_checker.sv
// Watches the evaluator's request and result channels, predicts each total and compares it.
module rpn_result_checker #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic [7:0]                              req_ch,
   input  logic                                    req_last,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [pfx_eval_pkg::DATA_W-1:0]  rsp_value,
   input  logic                                    rsp_error,
   output int                                      fail_count,
   output int                                      results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import pfx_eval_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     error;
   } rpn_total_type;

   rpn_total_type            totals_due[$];

   // predicted evaluator state
   logic signed [DATA_W-1:0] operands [STACK_DEPTH];
   int unsigned              depth_used;
   logic [63:0]              digits_acc;
   bit                       in_num;
   bit                       num_closed;
   bit                       skip_token;
   bit                       err_flag;
   logic signed [DATA_W-1:0] total;

   function automatic logic [127:0] abs_wide(input logic signed [DATA_W-1:0] v);
      logic signed [127:0] w;
      w = v;
      return (w < 0) ? -w : w;
   endfunction

   // clip a magnitude to the signed 48-bit range, flagging any clip
   function automatic logic signed [DATA_W-1:0] clamp(input bit neg, input logic [127:0] mag);
      logic [127:0] lim;
      logic [127:0] r;
      lim = neg ? 128'(NEG_MIN) : 128'(POS_MAX);
      if (mag > lim) begin
         err_flag = 1'b1;
         mag = lim;
      end
      r = neg ? -mag : mag;
      return r[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] add_sub(input bit subtract,
         input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] s;
      wa = a;
      wb = b;
      s = subtract ? wa - wb : wa + wb;
      return clamp(s < 0, (s < 0) ? -s : s);
   endfunction

   function automatic logic signed [DATA_W-1:0] fx_times(input logic signed [DATA_W-1:0] a,
         input logic signed [DATA_W-1:0] b);
      logic [127:0] p;
      p = abs_wide(a) * abs_wide(b);
      p = p >> FRAC_BITS;
      return clamp((a < 0) != (b < 0), p);
   endfunction

   function automatic logic signed [DATA_W-1:0] fx_quot(input logic signed [DATA_W-1:0] a,
         input logic signed [DATA_W-1:0] b);
      logic [127:0] q;
      if (b == 0) begin
         err_flag = 1'b1;
         if (a > 0) return POS_MAX;
         if (a < 0) return NEG_MIN;
         return '0;
      end
      q = (abs_wide(a) << FRAC_BITS) / abs_wide(b);
      return clamp((a < 0) != (b < 0), q);
   endfunction

   function automatic void push_operand(input logic signed [DATA_W-1:0] v);
      if (depth_used >= STACK_DEPTH) begin
         err_flag = 1'b1;
         return;
      end
      operands[depth_used] = v;
      depth_used++;
   endfunction

   function automatic void apply_op(input logic [7:0] c);
      logic signed [DATA_W-1:0] top;
      logic signed [DATA_W-1:0] below;
      logic signed [DATA_W-1:0] r;
      if (depth_used < 2) begin
         err_flag = 1'b1;
         return;
      end
      top   = operands[depth_used-1];
      below = operands[depth_used-2];
      depth_used -= 2;
      case (c)
         CH_PLUS:  r = add_sub(1'b0, below, top);
         CH_MINUS: r = add_sub(1'b1, below, top);
         CH_STAR:  r = fx_times(below, top);
         CH_SLASH: r = fx_quot(below, top);
         default:  return;
      endcase
      total = r;
      push_operand(r);
   endfunction

   function automatic void close_token();
      if (in_num) push_operand(DATA_W'(digits_acc << FRAC_BITS));
      in_num     = 1'b0;
      num_closed = 1'b0;
      skip_token = 1'b0;
      digits_acc = '0;
   endfunction

   function automatic void take_char(input logic [7:0] c, input logic is_last);
      bit          is_digit;
      logic [63:0] cap;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      cap = (64'd1 << (DATA_W - 1 - FRAC_BITS)) - 64'd1;
      if (c == CH_SPACE) begin
         close_token();
      end else if (in_num) begin
         if (is_digit && !num_closed) begin
            digits_acc = digits_acc * 10 + 64'(c - CH_ZERO);
            if (digits_acc > cap) begin
               digits_acc = cap;
               err_flag = 1'b1;
            end
         end else begin
            num_closed = 1'b1;
         end
      end else if (!skip_token) begin
         if (is_digit) begin
            in_num = 1'b1;
            num_closed = 1'b0;
            digits_acc = 64'(c - CH_ZERO);
            if (digits_acc > cap) begin
               digits_acc = cap;
               err_flag = 1'b1;
            end
         end else begin
            apply_op(c);
            skip_token = 1'b1;
         end
      end
      if (is_last) begin
         close_token();
         totals_due.push_back('{value: total, error: err_flag});
         depth_used = 0;
         total = '0;
         err_flag = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      rpn_total_type due;
      if (reset) begin
         totals_due.delete();
         depth_used = 0;
         digits_acc = '0;
         in_num = 1'b0;
         num_closed = 1'b0;
         skip_token = 1'b0;
         err_flag = 1'b0;
         total = '0;
      end else begin
         if (req_valid && !req_stall) take_char(req_ch, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (totals_due.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected: expected none, actual value %0d error %0b",
                        $time, rsp_value, rsp_error);
            end else begin
               due = totals_due.pop_front();
               if (rsp_value !== due.value) begin
                  fail_count++;
                  $display("%0t: value mismatch: expected %0d, actual %0d",
                           $time, due.value, rsp_value);
               end
               if (rsp_error !== due.error) begin
                  fail_count++;
                  $display("%0t: error flag mismatch: expected %0b, actual %0b",
                           $time, due.error, rsp_error);
               end
            end
         end
      end
      results_pending <= totals_due.size();
   end

endmodule

FILE: test/postfix_expression_evaluator_unit_tb.sv
// Stimulus and verdict for the postfix evaluator: directed and random expressions, random stalls.
module postfix_expression_evaluator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfx_eval_pkg::*;

   localparam int STACK_DEPTH  = 16;
   localparam int FRAC_BITS    = 16;
   localparam int CHAR_BUDGET  = 1550;  // requests to offer in total
   localparam int CALM_FROM    = 1300;  // no idling on either side from here on
   localparam int HOLD_AT      = 500;   // receiver's long hold-off starts here
   localparam int HOLD_CYCLES  = 1500;
   localparam int PAUSE_AT     = 900;   // sender drains the block here
   localparam int DRAIN_CYCLES = 100;   // covers the slowest request, a divide, plus margin

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_ch    = '0;
   logic                     req_last  = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic                     rsp_error;

   int                       fail_count;
   int                       results_pending;
   int                       chars_sent = 0;
   bit                       calm = 1'b0;

   // characters of the expression being built, sent front to back
   logic [7:0]               text_q[$];

   // hand-picked expressions: each operator, limits, and the odd token shapes
   string directed_exprs[] = '{
      " ",                                  // empty expression
      "3 4 +",
      "2 5 -",                              // negative total
      "6 7 *",
      "1 3 /",                              // fractional quotient
      "0 7 - 2 /",                          // negative fraction
      "5 0 /",                              // divide by zero, positive dividend
      "0 5 - 0 /",                          // divide by zero, negative dividend
      "0 0 /",                              // divide by zero, zero dividend
      "+",                                  // underflow, empty stack
      "5 *",                                // underflow, one operand
      "2147483647 2147483647 +",            // add saturates high
      "0 2147483647 - 2147483647 -",        // subtract saturates low
      "65536 65536 *",                      // product saturates
      "99999999999 1 *",                    // number too large
      "1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 + ",// stack overflow
      "3 4 +x- 2 *",                        // tail of operator token skipped
      "12a3 1 +",                           // non-digit ends a number
      "3\t4 +",                             // tab is a token character
      "  8   2  / ",                        // runs of spaces
      "9 9 q 4",                            // other token pops, pushes nothing
      "3 4 + 5",                            // number ended by the last character
      "1 2 + 3 * 4 - 5 /"
   };

   postfix_expression_evaluator_unit #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value),
      .rsp_error (rsp_error)
   );

   rpn_result_checker #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_error       (rsp_error),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- builders

   function automatic void add_str(input string s);
      foreach (s[i]) text_q.push_back(s[i]);
   endfunction

   // Mostly short numbers; now and then the top of the range or beyond it.
   function automatic void add_number();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         add_str($sformatf("%0d", $urandom_range(0, 99)));
      end else if (pick < 14) begin
         text_q.push_back(CH_ZERO);
      end else if (pick < 16) begin
         add_str($sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF)));
      end else if (pick == 16) begin
         add_str("2147483647");
      end else if (pick == 17) begin
         // too many digits: integer part clips
         n = $urandom_range(11, 13);
         repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end else if (pick == 18) begin
         add_str($sformatf("00%0d", $urandom_range(0, 9)));
      end else begin
         add_str($sformatf("%0d", $urandom_range(100, 99999)));
      end
   endfunction

   function automatic void add_operator();
      logic [7:0] ops[4];
      logic [7:0] b;
      int unsigned n;
      ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
      text_q.push_back(ops[$urandom_range(0, 3)]);
      // occasional junk tail on the operator token
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE);
            text_q.push_back(b);
         end
      end
   endfunction

   // Well-formed postfix with random content; deep ones overflow the stack.
   function automatic void build_rpn();
      int  target;
      int  depth;
      int  pushes;
      bit  deep;
      deep   = ($urandom_range(0, 19) == 0);
      target = deep ? $urandom_range(17, 19) : $urandom_range(1, 6);
      depth  = 0;
      pushes = 0;
      while (pushes < target || depth > 1) begin
         if (pushes < target && (depth < 2 || deep || $urandom_range(0, 1) == 1)) begin
            add_number();
            pushes++;
            depth++;
         end else begin
            add_operator();
            depth--;
         end
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(2, 3)) text_q.push_back(CH_SPACE);
         else text_q.push_back(CH_SPACE);
      end
      if (text_q.size() > 1 && $urandom_range(0, 1) == 1) void'(text_q.pop_back());
   endfunction

   // Break a good expression: overwrite or drop one character.
   function automatic void spoil_text();
      int unsigned p;
      p = $urandom_range(0, text_q.size() - 1);
      if (text_q.size() > 1 && $urandom_range(0, 1) == 1) text_q.delete(p);
      else text_q[p] = 8'($urandom_range(0, 255));
   endfunction

   function automatic void build_noise();
      int unsigned n;
      n = $urandom_range(1, 16);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) text_q.push_back(CH_SPACE);
         else text_q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // ---------------------------------------------------------------- driver

   // Send the built expression, one request per character, last on the final one.
   task automatic send_expr();
      bit steady;
      int i;
      steady = calm || ($urandom_range(0, 3) == 0);
      for (i = 0; i < text_q.size(); i++) begin
         if (!steady && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_ch    <= text_q[i];
         req_last  <= (i == text_q.size() - 1);
         do @(posedge clock); while (req_stall);
         chars_sent++;
      end
      text_q.delete();
   endtask

   // ---------------------------------------------------------------- receiver

   // Random stall bursts; one long hold-off so the block backs up and stalls
   // its own input; steady acceptance once the run is calm.
   initial begin : result_side
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && chars_sent >= HOLD_AT) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 12)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : request_side
      bit          drained;
      int unsigned kind;
      drained = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_exprs[k]) begin
         add_str(directed_exprs[k]);
         send_expr();
      end

      while (chars_sent < CHAR_BUDGET) begin
         if (chars_sent >= CALM_FROM) calm = 1'b1;
         // one pause with the block fully drained
         if (!drained && chars_sent >= PAUSE_AT) begin
            req_valid <= 1'b0;
            // the pending count is registered, so let it settle after the last request
            @(posedge clock);
            wait (results_pending == 0);
            @(posedge clock);
            drained = 1'b1;
         end
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            build_rpn();
         end else if (kind < 17) begin
            build_rpn();
            spoil_text();
         end else begin
            build_noise();
         end
         send_expr();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
